[rtl/kdlpr_pkg.sv]
// ----------------------------------------------------------------------------
// kdlpr_pkg: shared types and constants of the key debounce block
// Widths of the channel fields, register indexes, key phases, event codes,
// reset values of the configuration registers and the per-lane event record.
// ----------------------------------------------------------------------------
package kdlpr_pkg;

  // Fixed field widths
  localparam int KEY_LEVEL_W = 28;
  localparam int KEY_IDX_W   = 5;
  localparam int TICK_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 28;

  // Defaults of the top-level parameters
  localparam int NUM_KEYS_DEF     = 28;
  localparam int HISTORY_BITS_DEF = 8;

  // Register reset values
  localparam logic [TICK_W-1:0]      LONG_PRESS_RESET = 16'd100;
  localparam logic [TICK_W-1:0]      REPEAT_RESET     = 16'd20;
  localparam logic [KEY_LEVEL_W-1:0] CLICK_MASK_RESET = 28'hFFFFFFF;
  localparam logic [KEY_LEVEL_W-1:0] PRESS_MASK_RESET = 28'hFFFFF00;
  localparam logic                   REL_EN_RESET     = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS = 3'd0,
    REG_REPEAT     = 3'd1,
    REG_CLICK_MASK = 3'd2,
    REG_PRESS_MASK = 3'd3,
    REG_REL_EN     = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_CLICKED  = 2'd1,
    PH_LONG     = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    EV_CLICK   = 2'd0,
    EV_LONG    = 2'd1,
    EV_REPEAT  = 2'd2,
    EV_RELEASE = 2'd3
  } event_e;

  // Timing settings shared by every lane
  typedef struct packed {
    logic [TICK_W-1:0] long_ticks;
    logic [TICK_W-1:0] repeat_ticks;
    logic              rel_en;
  } lane_cfg_t;

  // What one lane found on the current tick
  typedef struct packed {
    logic   report;
    event_e kind;
  } lane_ev_t;

endpackage

[rtl/kdlpr_if.sv]
// ----------------------------------------------------------------------------
// kdlpr_if: channel interfaces of the key debounce block
// Scan tick channel, event channel and configuration write channel, each
// with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface kdlpr_tick_if;
  logic                               valid;
  logic                               ready;
  logic [kdlpr_pkg::KEY_LEVEL_W-1:0]  key_levels;

  modport source (output valid, output key_levels, input ready);
  modport sink   (input valid, input key_levels, output ready);
endinterface

interface kdlpr_event_if;
  logic                             valid;
  logic                             ready;
  logic [kdlpr_pkg::KEY_IDX_W-1:0]  key_index;
  logic [1:0]                       event_kind;
  logic                             last_event;

  modport source (output valid, output key_index, output event_kind,
                  output last_event, input ready);
  modport sink   (input valid, input key_index, input event_kind,
                  input last_event, output ready);
endinterface

interface kdlpr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [kdlpr_pkg::CFG_IDX_W-1:0]   index;
  logic [kdlpr_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/key_debounce_long_press_repeat.sv]
// ----------------------------------------------------------------------------
// key_debounce_long_press_repeat: debounced key scanner with long press
// Per-key lanes debounce the levels and run the press machines; a merge
// stage sends the resulting events out in ascending key order.
// ----------------------------------------------------------------------------
// Usage:
//   in_req_i  : one request per scan tick, key_levels bit k is key k (0 = down).
//   out_req_o : one request per reported event: key_index, event_kind
//               (click, long press, repeat, release), last_event set on the
//               final event of a tick.
//   cfg_req_i : register writes (index, data), always ready; write only while
//               the block is idle.
// Flow: the events of an accepted tick are captured as pending events and
//   then move to the output register; they follow one per cycle while the
//   receiver is ready. A new tick is taken as soon as the merge stage has
//   handed its last pending event to the output register, even if that
//   event still waits there.
// Stall: with out_req_o.ready low the output register holds its event and
//   the pending events wait, and with them the tick channel.
// Reset: histories cleared (a single low sample then gives a click), all
//   keys released, hold counters zero, registers at their default values.
// ----------------------------------------------------------------------------
module key_debounce_long_press_repeat #(
  parameter int NUM_KEYS     = kdlpr_pkg::NUM_KEYS_DEF,
  parameter int HISTORY_BITS = kdlpr_pkg::HISTORY_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  kdlpr_tick_if.sink     in_req_i,
  kdlpr_event_if.source  out_req_o,
  kdlpr_cfg_if.sink      cfg_req_i
);

  localparam int LevelW = kdlpr_pkg::KEY_LEVEL_W;

  // Configuration registers
  logic [kdlpr_pkg::TICK_W-1:0] long_ticks_q;
  logic [kdlpr_pkg::TICK_W-1:0] repeat_ticks_q;
  logic [LevelW-1:0]            click_mask_q;
  logic [LevelW-1:0]            press_mask_q;
  logic                         rel_en_q;

  kdlpr_pkg::lane_cfg_t                lane_cfg;
  kdlpr_pkg::lane_ev_t [NUM_KEYS-1:0]  lane_ev;
  logic                                tick;
  logic                                merge_idle;

  assign cfg_req_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ticks_q   <= kdlpr_pkg::LONG_PRESS_RESET;
      repeat_ticks_q <= kdlpr_pkg::REPEAT_RESET;
      click_mask_q   <= kdlpr_pkg::CLICK_MASK_RESET;
      press_mask_q   <= kdlpr_pkg::PRESS_MASK_RESET;
      rel_en_q       <= kdlpr_pkg::REL_EN_RESET;
    end else if (cfg_req_i.valid) begin
      // unknown indexes drop the write
      case (cfg_req_i.index)
        kdlpr_pkg::REG_LONG_PRESS: long_ticks_q   <= cfg_req_i.data[kdlpr_pkg::TICK_W-1:0];
        kdlpr_pkg::REG_REPEAT:     repeat_ticks_q <= cfg_req_i.data[kdlpr_pkg::TICK_W-1:0];
        kdlpr_pkg::REG_CLICK_MASK: click_mask_q   <= cfg_req_i.data[LevelW-1:0];
        kdlpr_pkg::REG_PRESS_MASK: press_mask_q   <= cfg_req_i.data[LevelW-1:0];
        kdlpr_pkg::REG_REL_EN:     rel_en_q       <= cfg_req_i.data[0];
        default: ;
      endcase
    end
  end

  assign lane_cfg.long_ticks   = long_ticks_q;
  assign lane_cfg.repeat_ticks = repeat_ticks_q;
  assign lane_cfg.rel_en       = rel_en_q;

  // Take a new tick once every pending event has left the merge stage
  assign in_req_i.ready = merge_idle;
  assign tick           = in_req_i.valid & merge_idle;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic level;
    logic click_en;
    logic press_en;

    if (k < LevelW) begin : g_wired
      assign level    = in_req_i.key_levels[k];
      assign click_en = click_mask_q[k];
      assign press_en = press_mask_q[k];
    end else begin : g_unwired
      // keys past the input width always read up and are never reported
      assign level    = 1'b1;
      assign click_en = 1'b0;
      assign press_en = 1'b0;
    end

    kdlpr_lane #(
      .HISTORY_BITS (HISTORY_BITS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tick_i     (tick),
      .level_i    (level),
      .click_en_i (click_en),
      .press_en_i (press_en),
      .cfg_i      (lane_cfg),
      .ev_o       (lane_ev[k])
    );
  end

  kdlpr_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick),
    .ev_i   (lane_ev),
    .idle_o (merge_idle),
    .evt_o  (out_req_o)
  );

endmodule

[rtl/kdlpr_lane.sv]
// ----------------------------------------------------------------------------
// kdlpr_lane: debounce and press machine of one key
// Shifts the sampled level into the history window, tracks the key phase
// and hold counter, and reports the event this tick causes for the key.
// ----------------------------------------------------------------------------
module kdlpr_lane #(
  parameter int HISTORY_BITS = kdlpr_pkg::HISTORY_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tick_i,      // scan tick accepted this cycle
  input  logic                  level_i,     // sampled level, low = pressed
  input  logic                  click_en_i,
  input  logic                  press_en_i,
  input  kdlpr_pkg::lane_cfg_t  cfg_i,
  output kdlpr_pkg::lane_ev_t   ev_o
);

  logic [HISTORY_BITS-1:0]        hist_q, hist_d;
  kdlpr_pkg::phase_e              phase_q, phase_d;
  logic [kdlpr_pkg::TICK_W-1:0]   hold_q, hold_d;
  logic [HISTORY_BITS:0]          shifted;
  logic [kdlpr_pkg::TICK_W-1:0]   hold_inc;
  logic                           down;

  assign shifted  = {hist_q, level_i};
  assign hist_d   = shifted[HISTORY_BITS-1:0];
  assign down     = (hist_d == '0);
  assign hold_inc = hold_q + 1'b1;

  always_comb begin
    phase_d        = phase_q;
    hold_d         = hold_q;
    ev_o.report    = 1'b0;
    ev_o.kind      = kdlpr_pkg::EV_CLICK;
    if (down) begin
      case (phase_q)
        kdlpr_pkg::PH_RELEASED: begin
          phase_d     = kdlpr_pkg::PH_CLICKED;
          ev_o.report = click_en_i;
        end
        kdlpr_pkg::PH_CLICKED: begin
          hold_d = hold_inc;
          if (hold_inc == cfg_i.long_ticks) begin
            hold_d      = '0;
            phase_d     = kdlpr_pkg::PH_LONG;
            ev_o.kind   = kdlpr_pkg::EV_LONG;
            ev_o.report = press_en_i;
          end
        end
        kdlpr_pkg::PH_LONG: begin
          hold_d = hold_inc;
          if (hold_inc == cfg_i.repeat_ticks) begin
            hold_d      = '0;
            ev_o.kind   = kdlpr_pkg::EV_REPEAT;
            ev_o.report = press_en_i;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end else if (phase_q != kdlpr_pkg::PH_RELEASED) begin
      // any high sample drops the key at once
      phase_d     = kdlpr_pkg::PH_RELEASED;
      hold_d      = '0;
      ev_o.kind   = kdlpr_pkg::EV_RELEASE;
      ev_o.report = cfg_i.rel_en;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q  <= '0;
      phase_q <= kdlpr_pkg::PH_RELEASED;
      hold_q  <= '0;
    end else if (tick_i) begin
      hist_q  <= hist_d;
      phase_q <= phase_d;
      hold_q  <= hold_d;
    end
  end

endmodule

[rtl/kdlpr_merge.sv]
// ----------------------------------------------------------------------------
// kdlpr_merge: event merge and output stage
// Captures the lane events of a tick and sends them out one per cycle, while
// the receiver is ready, in ascending key order through an output register.
// ----------------------------------------------------------------------------
module kdlpr_merge #(
  parameter int NUM_KEYS = kdlpr_pkg::NUM_KEYS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                tick_i,
  input  kdlpr_pkg::lane_ev_t [NUM_KEYS-1:0]  ev_i,
  output logic                                idle_o,   // no event pending in the merge stage
  kdlpr_event_if.source                       evt_o
);

  localparam int KeyW = kdlpr_pkg::KEY_IDX_W;

  logic [NUM_KEYS-1:0]           pend_q;
  logic [NUM_KEYS-1:0]           pend_d;
  kdlpr_pkg::event_e [NUM_KEYS-1:0] kind_q;
  logic [NUM_KEYS-1:0]           low_bit;
  logic [NUM_KEYS-1:0]           rest;
  logic [KeyW-1:0]               sel_idx;
  kdlpr_pkg::event_e             sel_kind;
  logic                          issue;
  logic                          out_valid_q;
  logic [KeyW-1:0]               out_idx_q;
  kdlpr_pkg::event_e             out_kind_q;
  logic                          out_last_q;

  assign low_bit = pend_q & (~pend_q + 1'b1);
  assign rest    = pend_q & ~low_bit;
  assign issue   = (pend_q != '0) && (!out_valid_q || evt_o.ready);
  assign idle_o  = (pend_q == '0);

  always_comb begin
    sel_idx  = '0;
    sel_kind = kdlpr_pkg::EV_CLICK;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (low_bit[k]) begin
        sel_idx  = KeyW'(k);
        sel_kind = kind_q[k];
      end
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (tick_i) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        pend_d[k] = ev_i[k].report;
      end
    end else if (issue) begin
      pend_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (evt_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (tick_i) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        kind_q[k] <= ev_i[k].kind;
      end
    end
    if (issue) begin
      out_idx_q  <= sel_idx;
      out_kind_q <= sel_kind;
      out_last_q <= (rest == '0);
    end
  end

  assign evt_o.valid      = out_valid_q;
  assign evt_o.key_index  = out_idx_q;
  assign evt_o.event_kind = out_kind_q;
  assign evt_o.last_event = out_last_q;

endmodule

[test/kdlpr_event_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlpr_event_checker: scoreboard of the key debounce block
// Watches the scan tick, event and register write channels. Predicts the key
// events of every accepted tick and compares each event in order.
// ----------------------------------------------------------------------------
module kdlpr_event_checker
  import kdlpr_pkg::*;
#(
  parameter int NUM_KEYS     = NUM_KEYS_DEF,
  parameter int HISTORY_BITS = HISTORY_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  kdlpr_tick_if  tick_mon,
  kdlpr_event_if event_mon,
  kdlpr_cfg_if   cfg_mon,
  output int     fail_count_o,
  output int     outstanding_o,
  output int     checked_o
);

  typedef struct {
    logic [KEY_IDX_W-1:0] key_index;
    event_e               kind;
    logic                 last_event;
  } key_event_t;

  // Model copy of the per-key state and the registers
  logic [HISTORY_BITS-1:0] level_window [NUM_KEYS];
  phase_e                  key_state    [NUM_KEYS];
  logic [TICK_W-1:0]       hold_count   [NUM_KEYS];
  logic [TICK_W-1:0]       long_ticks;
  logic [TICK_W-1:0]       repeat_ticks;
  logic [KEY_LEVEL_W-1:0]  click_mask;
  logic [KEY_LEVEL_W-1:0]  press_mask;
  logic                    release_en;

  key_event_t due_events [$];
  key_event_t head;

  // Advance every key by one scan tick and queue the events it reports.
  task automatic scan_tick(input logic [KEY_LEVEL_W-1:0] levels);
    int     reported;
    logic   report;
    event_e kind;
    reported = 0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      report = 1'b0;
      kind   = EV_CLICK;
      level_window[k] = HISTORY_BITS'({level_window[k], levels[k]});
      if (level_window[k] == '0) begin
        case (key_state[k])
          PH_RELEASED: begin
            key_state[k] = PH_CLICKED;
            kind         = EV_CLICK;
            report       = click_mask[k];
          end
          PH_CLICKED: begin
            hold_count[k] = hold_count[k] + 1'b1;
            if (hold_count[k] == long_ticks) begin
              hold_count[k] = '0;
              key_state[k]  = PH_LONG;
              kind          = EV_LONG;
              report        = press_mask[k];
            end
          end
          PH_LONG: begin
            hold_count[k] = hold_count[k] + 1'b1;
            if (hold_count[k] == repeat_ticks) begin
              hold_count[k] = '0;
              kind          = EV_REPEAT;
              report        = press_mask[k];
            end
          end
          default: ;
        endcase
      end else if (key_state[k] != PH_RELEASED) begin
        hold_count[k] = '0;
        key_state[k]  = PH_RELEASED;
        kind          = EV_RELEASE;
        report        = release_en;
      end
      if (report) begin
        due_events.push_back('{KEY_IDX_W'(k), kind, 1'b0});
        reported++;
      end
    end
    if (reported > 0) due_events[due_events.size()-1].last_event = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        level_window[k] = '0;
        key_state[k]    = PH_RELEASED;
        hold_count[k]   = '0;
      end
      long_ticks   = LONG_PRESS_RESET;
      repeat_ticks = REPEAT_RESET;
      click_mask   = CLICK_MASK_RESET;
      press_mask   = PRESS_MASK_RESET;
      release_en   = REL_EN_RESET;
      due_events.delete();
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      // Events belong to older ticks, so compare before queuing new ones.
      if (event_mon.valid && event_mon.ready) begin
        if (due_events.size() == 0) begin
          $error("unexpected event: key_index %0d event_kind %0d last_event %0d",
                 event_mon.key_index, event_mon.event_kind, event_mon.last_event);
          fail_count_o++;
        end else begin
          head = due_events.pop_front();
          checked_o++;
          if (event_mon.key_index !== head.key_index) begin
            $error("key_index: expected %0d, actual %0d",
                   head.key_index, event_mon.key_index);
            fail_count_o++;
          end
          if (event_mon.event_kind !== head.kind) begin
            $error("event_kind: expected %0d, actual %0d",
                   head.kind, event_mon.event_kind);
            fail_count_o++;
          end
          if (event_mon.last_event !== head.last_event) begin
            $error("last_event: expected %0d, actual %0d",
                   head.last_event, event_mon.last_event);
            fail_count_o++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_LONG_PRESS: long_ticks   = cfg_mon.data[TICK_W-1:0];
          REG_REPEAT:     repeat_ticks = cfg_mon.data[TICK_W-1:0];
          REG_CLICK_MASK: click_mask   = cfg_mon.data[KEY_LEVEL_W-1:0];
          REG_PRESS_MASK: press_mask   = cfg_mon.data[KEY_LEVEL_W-1:0];
          REG_REL_EN:     release_en   = cfg_mon.data[0];
          default: ;
        endcase
      end
      if (tick_mon.valid && tick_mon.ready) scan_tick(tick_mon.key_levels);
    end
    outstanding_o = due_events.size();
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the key debounce, long press and auto repeat block
// Drives scan ticks with random gaps and register writes, throttles the event
// receiver, and lets the checker predict and compare every key event.
// ----------------------------------------------------------------------------
module tb;
  import kdlpr_pkg::*;

  localparam int NUM_KEYS        = NUM_KEYS_DEF;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 8;
  localparam int RANDOM_TICKS    = 23;
  localparam int WATCHDOG_NS     = 2_000_000;
  // First register index that the block leaves unused
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;

  logic clk_i;
  logic rst_ni;

  int max_gap       = 4;
  bit hold_off_req  = 1'b0;
  int ticks_sent    = 0;
  int cfg_writes    = 0;
  int fail_count;
  int outstanding;
  int events_checked;

  // Keys the random sequences treat as held down (one = pressed)
  logic [KEY_LEVEL_W-1:0] pressed_keys;

  kdlpr_tick_if  tick_ch  ();
  kdlpr_event_if event_ch ();
  kdlpr_cfg_if   cfg_ch   ();

  key_debounce_long_press_repeat i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (tick_ch),
    .out_req_o (event_ch),
    .cfg_req_i (cfg_ch)
  );

  kdlpr_event_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_mon      (tick_ch),
    .event_mon     (event_ch),
    .cfg_mon       (cfg_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .checked_o     (events_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the run: far beyond the slowest legal run.
  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("timeout: %0d events still expected", outstanding);
    $display("RESULT: ERROR");
    $finish;
  end

  // Event receiver: stall a random number of cycles before taking each
  // request, and hold off for a long stretch once when asked to.
  initial begin : event_receiver
    int stall;
    event_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        event_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      stall = $urandom_range(0, max_gap);
      if (stall > 0) begin
        event_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      event_ch.ready <= 1'b1;
      // Wait for the request to be taken
      @(posedge clk_i);
      while (!event_ch.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Offer one scan tick after a random gap and hold it until accepted.
  // Valid stays high on return so that back-to-back ticks need no toggle.
  task automatic send_tick(input logic [KEY_LEVEL_W-1:0] levels);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.key_levels <= levels;
    @(posedge clk_i);
    while (!tick_ch.ready) @(posedge clk_i);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Drop the tick channel, wait for every expected event, then let the
  // pipeline empty out ticks that report nothing.
  task automatic settle();
    tick_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_writes++;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Small thresholds so that long presses and repeats show up within a
  // phase; masks and release reporting drawn at random.
  task automatic cfg_random();
    cfg_write(REG_LONG_PRESS, CFG_DATA_W'($urandom_range(1, 6)));
    cfg_write(REG_REPEAT,     CFG_DATA_W'($urandom_range(1, 4)));
    cfg_write(REG_CLICK_MASK, CFG_DATA_W'($urandom));
    cfg_write(REG_PRESS_MASK, CFG_DATA_W'($urandom));
    cfg_write(REG_REL_EN,     CFG_DATA_W'($urandom_range(0, 1)));
  endtask

  // Mostly steady key patterns: keys go down and up now and then, with
  // occasional bounce on one key and rare ticks of pure noise.
  task automatic random_ticks(input int count);
    logic [KEY_LEVEL_W-1:0] levels;
    int                     idx;
    pressed_keys = KEY_LEVEL_W'($urandom);
    repeat (count) begin
      if ($urandom_range(0, 2) == 0) begin
        idx = $urandom_range(0, NUM_KEYS - 1);
        pressed_keys[idx] = ~pressed_keys[idx];
      end
      if ($urandom_range(0, 19) == 0) pressed_keys ^= KEY_LEVEL_W'($urandom);
      levels = ~pressed_keys;
      if ($urandom_range(0, 5) == 0) begin
        idx = $urandom_range(0, NUM_KEYS - 1);
        levels[idx] = ~levels[idx];
      end
      if ($urandom_range(0, 24) == 0) levels = KEY_LEVEL_W'($urandom);
      send_tick(levels);
    end
  endtask

  initial begin : stimulus
    // Known values on every input before reset releases
    rst_ni             = 1'b0;
    tick_ch.valid      = 1'b0;
    tick_ch.key_levels = '1;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_LONG_PRESS;
    cfg_ch.data        = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Default registers. Histories start cleared, so the first low sample
    // clicks every key at once; releases are suppressed.
    send_tick('0);
    send_tick('1);
    send_tick(28'h5555555);
    send_tick(28'hAAAAAAA);
    settle();

    // Thresholds of one, all reports on. Junk above the register width
    // must be dropped, and writes to unused indexes must change nothing.
    cfg_write(REG_LONG_PRESS, 28'hABC0001);
    cfg_write(REG_REPEAT,     28'h5550001);
    cfg_write(REG_CLICK_MASK, '1);
    cfg_write(REG_PRESS_MASK, '1);
    cfg_write(REG_REL_EN,     '1);
    for (int i = REG_SPARE_FIRST; i < (1 << CFG_IDX_W); i++) begin
      cfg_write(CFG_IDX_W'(i), '0);
    end

    // Hold every key through debounce: clicks, long presses, repeats, and
    // then all releases. The receiver holds off meanwhile so the block
    // backs up and stalls the tick channel.
    hold_off_req = 1'b1;
    repeat (HISTORY_BITS_DEF + 2) send_tick('0);
    send_tick('1);
    settle();

    // Largest thresholds: no long press can be reached in this phase.
    cfg_write(REG_LONG_PRESS, '1);
    cfg_write(REG_REPEAT,     '1);
    cfg_write(REG_CLICK_MASK, '1);
    cfg_write(REG_PRESS_MASK, '0);
    cfg_write(REG_REL_EN,     '1);
    random_ticks(RANDOM_TICKS);
    settle();

    cfg_random();
    random_ticks(RANDOM_TICKS);
    settle();

    // Back-to-back traffic on both sides
    max_gap = 0;
    cfg_random();
    random_ticks(RANDOM_TICKS);
    settle();

    max_gap = 4;
    cfg_random();
    random_ticks(RANDOM_TICKS);
    settle();

    // Zero long press threshold: key 0 held down must not long-press
    // before its hold counter laps round, so nothing is reported here.
    cfg_write(REG_LONG_PRESS, '0);
    cfg_write(REG_REPEAT,     CFG_DATA_W'(1));
    cfg_write(REG_CLICK_MASK, '0);
    cfg_write(REG_PRESS_MASK, CFG_DATA_W'(1));
    cfg_write(REG_REL_EN,     '0);
    send_tick('1);
    repeat (HISTORY_BITS_DEF + 4) send_tick(~KEY_LEVEL_W'(1));
    send_tick('1);
    settle();

    $display("Run covered %0d scan ticks and %0d register writes; %0d key events checked,",
             ticks_sent, cfg_writes, events_checked);
    $display("with all event kinds, a %0d-cycle receiver hold-off and a zero threshold.",
             HOLD_OFF_CYCLES);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/kdlpr_pkg.sv
rtl/kdlpr_if.sv
rtl/kdlpr_lane.sv
rtl/kdlpr_merge.sv
rtl/key_debounce_long_press_repeat.sv
test/kdlpr_event_checker.sv
test/tb.sv
